### design/mtwt_pkg.sv
package mtwt_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 16;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [30:0] TIMEOUT_RESET = 31'd10000;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_REPORT   = 2'd1,
		OP_CHECK    = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_MISSING = 3'd1,
		ST_NONAME  = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_ZERO_ID = 3'd5
	} status_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		op_t         op;
		status_t     pre_status;
		logic [63:0] thread_id;
		logic [31:0] now_ms;
	} cmd_t;

endpackage

### design/mtwt_front.sv
module mtwt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [63:0]       thread_id,
	input  logic [31:0]       now_ms,
	input  logic              thread_alive,
	input  logic              name_given,
	output logic              cmd_valid,
	output mtwt_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);

	localparam int unsigned PW = (mtwt_pkg::QUEUE_DEPTH > 1) ?
		$clog2(mtwt_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(mtwt_pkg::QUEUE_DEPTH + 1);

	mtwt_pkg::cmd_t queue_q [mtwt_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FW-1:0]  fill_q;
	mtwt_pkg::cmd_t new_cmd;
	logic           push;
	logic           pop;

	// Checks that need no table state are settled here, before queueing.
	always_comb begin
		new_cmd.op         = mtwt_pkg::op_t'(op);
		new_cmd.thread_id  = thread_id;
		new_cmd.now_ms     = now_ms;
		new_cmd.pre_status = mtwt_pkg::ST_OK;
		case (mtwt_pkg::op_t'(op))
			mtwt_pkg::OP_REGISTER: begin
				if (!thread_alive) begin
					new_cmd.pre_status = mtwt_pkg::ST_MISSING;
				end else if (!name_given) begin
					new_cmd.pre_status = mtwt_pkg::ST_NONAME;
				end
			end
			mtwt_pkg::OP_REPORT: begin
				if (thread_id == 64'd0) begin
					new_cmd.pre_status = mtwt_pkg::ST_ZERO_ID;
				end
			end
			default: begin
				new_cmd.pre_status = mtwt_pkg::ST_OK;
			end
		endcase
	end

	assign in_ready  = (fill_q != FW'(mtwt_pkg::QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(mtwt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(mtwt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

### design/mtwt_back.sv
module mtwt_back #(
	parameter int unsigned MAX_ENTRIES = mtwt_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  mtwt_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              cfg_we,
	input  logic [30:0]       cfg_wdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic              expired,
	output logic [63:0]       expired_thread_id,
	output logic [31:0]       elapsed_ms
);

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	logic [63:0]       mem_tid  [MAX_ENTRIES];
	logic [31:0]       mem_time [MAX_ENTRIES];

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     scan_idx_q, scan_d;
	mtwt_pkg::cmd_t    cur_q;
	logic [30:0]       timeout_q;
	logic [63:0]       rd_tid_q;
	logic [31:0]       rd_time_q;
	logic              out_valid_q;
	mtwt_pkg::status_t status_q;
	logic              expired_q;
	logic [63:0]       exp_id_q;
	logic [31:0]       elapsed_q;

	logic              fin;
	mtwt_pkg::status_t r_status;
	logic              r_exp;
	logic [63:0]       r_id;
	logic [31:0]       r_el;
	logic              tid_we;
	logic              time_we;
	logic [IW-1:0]     wr_addr;
	logic [31:0]       wr_time;
	logic [IW-1:0]     rd_addr;
	logic [31:0]       diff;
	logic              is_last;
	logic              table_full;

	assign diff       = cur_q.now_ms - rd_time_q;
	assign is_last    = (CW'(scan_idx_q) + CW'(1) == count_q);
	assign table_full = (count_q == CW'(MAX_ENTRIES));

	always_comb begin
		cmd_pop  = 1'b0;
		fin      = 1'b0;
		r_status = mtwt_pkg::ST_OK;
		r_exp    = 1'b0;
		r_id     = '0;
		r_el     = '0;
		tid_we   = 1'b0;
		time_we  = 1'b0;
		wr_addr  = count_q[IW-1:0];
		wr_time  = cmd.now_ms;
		count_d  = count_q;
		state_d  = state_q;
		scan_d   = scan_idx_q;
		rd_addr  = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						mtwt_pkg::OP_REGISTER: begin
							fin = 1'b1;
							if (cmd.pre_status != mtwt_pkg::ST_OK) begin
								r_status = cmd.pre_status;
							end else if (table_full) begin
								r_status = mtwt_pkg::ST_FULL;
							end else begin
								tid_we  = 1'b1;
								time_we = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						mtwt_pkg::OP_REPORT: begin
							if (cmd.pre_status != mtwt_pkg::ST_OK) begin
								fin      = 1'b1;
								r_status = cmd.pre_status;
							end else if (count_q == '0) begin
								fin      = 1'b1;
								r_status = mtwt_pkg::ST_UNKNOWN;
							end else begin
								state_d = S_SCAN;
								scan_d  = '0;
							end
						end
						mtwt_pkg::OP_CHECK: begin
							if (count_q == '0) begin
								fin = 1'b1;
							end else begin
								state_d = S_SCAN;
								scan_d  = '0;
							end
						end
						default: begin
							fin     = 1'b1;
							count_d = '0;
						end
					endcase
				end
			end
			S_SCAN: begin
				// The read for the next entry is issued while this one is compared.
				rd_addr = (scan_idx_q == IW'(MAX_ENTRIES - 1)) ? '0 : scan_idx_q + IW'(1);
				if (cur_q.op == mtwt_pkg::OP_REPORT) begin
					if (rd_tid_q == cur_q.thread_id) begin
						fin     = 1'b1;
						time_we = 1'b1;
						wr_addr = scan_idx_q;
						wr_time = cur_q.now_ms;
					end
				end else begin
					// A negative elapsed time never counts as expired.
					if (!diff[31] && (diff[30:0] > timeout_q)) begin
						fin   = 1'b1;
						r_exp = 1'b1;
						r_id  = rd_tid_q;
						r_el  = diff;
					end
				end
				if (!fin) begin
					if (is_last) begin
						fin = 1'b1;
						if (cur_q.op == mtwt_pkg::OP_REPORT) begin
							r_status = mtwt_pkg::ST_UNKNOWN;
						end
					end else begin
						scan_d = scan_idx_q + IW'(1);
					end
				end
				if (fin) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tid_we) begin
			mem_tid[wr_addr] <= cmd.thread_id;
		end
		if (time_we) begin
			mem_time[wr_addr] <= wr_time;
		end
		rd_tid_q  <= mem_tid[rd_addr];
		rd_time_q <= mem_time[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (fin) begin
			status_q  <= r_status;
			expired_q <= r_exp;
			exp_id_q  <= r_id;
			elapsed_q <= r_el;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			timeout_q   <= mtwt_pkg::TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			scan_idx_q <= scan_d;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign expired           = expired_q;
	assign expired_thread_id = exp_id_q;
	assign elapsed_ms        = elapsed_q;

endmodule

### design/multi_thread_watchdog_table.sv
// Register, clear and refused items, and any item on an empty table, finish without a
// table scan. Report and check otherwise read one table entry per cycle, and stop at
// the first match or after the last entry.
// One item is worked at a time and the next starts once the result is taken. A two-item
// queue takes new items meanwhile. Reset empties the table and sets the timeout to
// 10000 ms.
module multi_thread_watchdog_table #(
	parameter int unsigned MAX_ENTRIES = mtwt_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] thread_id,
	input  logic [31:0] now_ms,
	input  logic        thread_alive,
	input  logic        name_given,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        expired,
	output logic [63:0] expired_thread_id,
	output logic [31:0] elapsed_ms,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);

	logic           cmd_valid;
	logic           cmd_pop;
	mtwt_pkg::cmd_t cmd;

	mtwt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.thread_id    (thread_id),
		.now_ms       (now_ms),
		.thread_alive (thread_alive),
		.name_given   (name_given),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	mtwt_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.expired           (expired),
		.expired_thread_id (expired_thread_id),
		.elapsed_ms        (elapsed_ms)
	);

endmodule
